// File: hw/rtl/sgm_pkg.sv
// sgm_pkg: shared types and constants for the Sobel gradient magnitude unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sgm_pkg;

	// configuration register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FW_W       = 12;
	localparam int FH_W       = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER_MODE  = 2'd2;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic            BORDER_MODE_RST  = 1'b1;

	typedef enum logic [1:0] {
		F_IDLE,
		F_READ,
		F_EMIT
	} sgm_front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SQR,
		B_ADD,
		B_ROOT,
		B_OUT
	} sgm_back_state_t;

	typedef struct packed {
		logic run_last;
		logic frame_done;
	} sgm_flags_t;

endpackage
`default_nettype wire

// File: hw/rtl/sgm_fifo.sv
// sgm_fifo: small register queue between the front and back parts.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module sgm_fifo #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic [DATA_W-1:0]      pop_data,
	output logic                   empty
);
	localparam int PW = $clog2(DEPTH);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       count_q;
	logic              do_push, do_pop;

	assign full     = (count_q == (PW + 1)'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/sgm_front.sv
// sgm_front: pixel intake, line store, 3x3 window, counters and border handling.
// Emits one gradient job per result into the queue. Depends on sgm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sgm_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096,
	parameter int PIXEL_BITS = 8,
	parameter int JOB_W      = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 2 * (PIXEL_BITS + 3) + 2
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sgm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sgm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           pixel_valid,
	output logic                                pixel_ready,
	input  wire logic [PIXEL_BITS-1:0]          pixel,
	output logic                                job_push,
	output logic [JOB_W-1:0]                    job_data,
	input  wire logic                           job_full
);
	import sgm_pkg::*;

	localparam int P  = PIXEL_BITS;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int GW = P + 3;
	localparam int SW = P + 2;
	localparam logic [13:0] WMAX = 14'(MAX_WIDTH);
	localparam logic [16:0] HMAX = 17'(MAX_HEIGHT);

	sgm_front_state_t state_q, state_d;

	logic [FW_W-1:0] width_q;
	logic [FH_W-1:0] height_q;
	logic            border_q;

	logic [CW-1:0]  col_q, it_col_q;
	logic [RW-1:0]  row_q, it_row_q;
	logic [P-1:0]   pix_q;
	logic [2*P-1:0] line_mem [MAX_WIDTH];
	logic [2*P-1:0] rd_q;
	logic [9*P-1:0] win_q, win_shift;
	logic [3:0]     mask_q, mask_new, kind_hot, mask_left;

	logic [13:0] w_ext, w_cl, wm1;
	logic [16:0] h_ext, h_cl, hm1;
	logic        row_end, last_row, accept;

	logic        lower, east;
	logic [1:0]  rsel [3];
	logic [1:0]  csel [3];
	logic        rout [3];
	logic        cout [3];
	logic [P-1:0] g [3][3];
	logic [SW-1:0] left_s, right_s, up_s, down_s;
	logic signed [GW-1:0] gx, gy;
	logic [CW-1:0] job_col;
	logic [RW-1:0] job_row;
	sgm_flags_t    flags;

	function automatic logic [P-1:0] pick(input logic [9*P-1:0] win,
	                                     input logic [1:0] rr, input logic [1:0] cc);
		logic [P-1:0] v;
		v = '0;
		unique case ({rr, cc})
			4'b0000: v = win[0*P +: P];
			4'b0001: v = win[1*P +: P];
			4'b0010: v = win[2*P +: P];
			4'b0100: v = win[3*P +: P];
			4'b0101: v = win[4*P +: P];
			4'b0110: v = win[5*P +: P];
			4'b1000: v = win[6*P +: P];
			4'b1001: v = win[7*P +: P];
			4'b1010: v = win[8*P +: P];
			default: v = '0;
		endcase
		return v;
	endfunction

	// saturated frame size
	always_comb begin
		w_ext = 14'(width_q);
		if (w_ext < 14'd3) w_cl = 14'd3;
		else if (w_ext > WMAX) w_cl = WMAX;
		else w_cl = w_ext;
		wm1 = w_cl - 14'd1;
		h_ext = 17'(height_q);
		if (h_ext < 17'd3) h_cl = 17'd3;
		else if (h_ext > HMAX) h_cl = HMAX;
		else h_cl = h_ext;
		hm1 = h_cl - 17'd1;
	end

	assign row_end  = 14'(it_col_q) >= wm1;
	assign last_row = 17'(it_row_q) >= hm1;
	assign accept   = pixel_valid && pixel_ready;

	always_comb begin
		win_shift = win_q;
		for (int i = 0; i < 3; i++) begin
			win_shift[(i*3+0)*P +: P] = win_q[(i*3+1)*P +: P];
			win_shift[(i*3+1)*P +: P] = win_q[(i*3+2)*P +: P];
		end
		win_shift[2*P +: P] = rd_q[2*P-1:P];
		win_shift[5*P +: P] = rd_q[P-1:0];
		win_shift[8*P +: P] = pix_q;
	end

	always_comb begin
		mask_new[0] = (it_row_q != '0) && (it_col_q != '0);
		mask_new[1] = (it_row_q != '0) && row_end;
		mask_new[2] = (it_row_q != '0) && last_row && (it_col_q != '0);
		mask_new[3] = (it_row_q != '0) && last_row && row_end;
	end

	// lowest pending result first
	always_comb begin
		priority if (mask_q[0]) kind_hot = 4'b0001;
		else if (mask_q[1]) kind_hot = 4'b0010;
		else if (mask_q[2]) kind_hot = 4'b0100;
		else kind_hot = 4'b1000;
	end
	assign mask_left = mask_q & ~kind_hot;
	assign lower     = kind_hot[2] || kind_hot[3];
	assign east      = kind_hot[1] || kind_hot[3];

	// neighbor selection with frame border handling
	always_comb begin
		if (lower) begin
			rsel[0] = 2'd1; rout[0] = 1'b0;
			rsel[1] = 2'd2; rout[1] = 1'b0;
			rsel[2] = 2'd2; rout[2] = 1'b1;
		end else begin
			rout[0] = (it_row_q == RW'(1));
			rsel[0] = rout[0] ? 2'd1 : 2'd0;
			rsel[1] = 2'd1; rout[1] = 1'b0;
			rsel[2] = 2'd2; rout[2] = 1'b0;
		end
		if (east) begin
			cout[0] = (it_col_q == '0);
			csel[0] = cout[0] ? 2'd2 : 2'd1;
			csel[1] = 2'd2; cout[1] = 1'b0;
			csel[2] = 2'd2; cout[2] = 1'b1;
		end else begin
			cout[0] = (it_col_q == CW'(1));
			csel[0] = cout[0] ? 2'd1 : 2'd0;
			csel[1] = 2'd1; cout[1] = 1'b0;
			csel[2] = 2'd2; cout[2] = 1'b0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				g[i][j] = ((rout[i] || cout[j]) && !border_q) ? '0 :
				          pick(win_q, rsel[i], csel[j]);
			end
		end
	end

	always_comb begin
		left_s  = SW'(g[0][0]) + (SW'(g[1][0]) << 1) + SW'(g[2][0]);
		right_s = SW'(g[0][2]) + (SW'(g[1][2]) << 1) + SW'(g[2][2]);
		up_s    = SW'(g[0][0]) + (SW'(g[0][1]) << 1) + SW'(g[0][2]);
		down_s  = SW'(g[2][0]) + (SW'(g[2][1]) << 1) + SW'(g[2][2]);
		gx = $signed({1'b0, left_s}) - $signed({1'b0, right_s});
		gy = $signed({1'b0, up_s}) - $signed({1'b0, down_s});
		job_col = east ? it_col_q : it_col_q - 1'b1;
		job_row = lower ? it_row_q : it_row_q - 1'b1;
		flags.run_last   = (mask_left == '0);
		flags.frame_done = kind_hot[3];
	end

	assign job_data = {job_col, job_row, gx, gy, flags};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (pixel_valid) state_d = F_READ;
			F_READ: state_d = (mask_new != '0) ? F_EMIT : F_IDLE;
			F_EMIT: if (!job_full && mask_left == '0) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		pixel_ready = (state_q == F_IDLE);
		job_push    = (state_q == F_EMIT) && !job_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
			border_q <= BORDER_MODE_RST;
			col_q    <= '0;
			row_q    <= '0;
			win_q    <= '0;
			mask_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  width_q  <= cfg_wdata[FW_W-1:0];
					REG_FRAME_HEIGHT: height_q <= cfg_wdata[FH_W-1:0];
					REG_BORDER_MODE:  border_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (state_q == F_READ) begin
				win_q  <= win_shift;
				mask_q <= mask_new;
				if (row_end) begin
					col_q <= '0;
					row_q <= last_row ? '0 : it_row_q + 1'b1;
				end else begin
					col_q <= it_col_q + 1'b1;
				end
			end else if (job_push) begin
				mask_q <= mask_left;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q    <= pixel;
			it_col_q <= col_q;
			it_row_q <= row_q;
			rd_q     <= line_mem[col_q];
		end
		if (state_q == F_READ) begin
			line_mem[it_col_q] <= {rd_q[P-1:0], pix_q};
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/sgm_back.sv
// sgm_back: squares the gradients, takes the integer square root one result bit
// per cycle and holds the result in the output register. Depends on sgm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sgm_back #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096,
	parameter int PIXEL_BITS = 8,
	parameter int JOB_W      = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 2 * (PIXEL_BITS + 3) + 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          job_empty,
	output logic                               job_pop,
	input  wire logic [JOB_W-1:0]              job_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [$clog2(MAX_WIDTH)-1:0]       out_col,
	output logic [$clog2(MAX_HEIGHT)-1:0]      out_row,
	output logic signed [PIXEL_BITS+2:0]       grad_x,
	output logic signed [PIXEL_BITS+2:0]       grad_y,
	output logic [PIXEL_BITS+2:0]              magnitude,
	output logic                               run_last,
	output logic                               frame_done
);
	import sgm_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int GW  = PIXEL_BITS + 3;
	localparam int MW  = GW;
	localparam int VW  = 2 * GW;
	localparam int RMW = MW + 2;
	localparam int NW  = $clog2(MW);

	sgm_back_state_t state_q, state_d;

	logic [CW-1:0]        col_q;
	logic [RW-1:0]        row_q;
	logic signed [GW-1:0] gx_q, gy_q;
	sgm_flags_t           flags_q;
	logic [VW-1:0]        sqx_q, sqy_q, val_q;
	logic [RMW-1:0]       rem_q, rem_in, trial;
	logic [MW-1:0]        root_q;
	logic [NW-1:0]        cnt_q;
	logic                 take, load_out;
	logic                 out_valid_q;

	assign rem_in = {rem_q[MW-1:0], val_q[VW-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!job_empty) state_d = B_SQR;
			B_SQR:  state_d = B_ADD;
			B_ADD:  state_d = B_ROOT;
			B_ROOT: if (cnt_q == '0) state_d = B_OUT;
			B_OUT:  if (!out_valid_q || out_ready) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		take     = (state_q == B_IDLE) && !job_empty;
		job_pop  = take;
		load_out = (state_q == B_OUT) && (!out_valid_q || out_ready);
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			{col_q, row_q, gx_q, gy_q, flags_q} <= job_data;
		end
		// operands widened before the product so the full square is kept
		if (state_q == B_SQR) begin
			sqx_q <= VW'($unsigned(VW'(gx_q) * VW'(gx_q)));
			sqy_q <= VW'($unsigned(VW'(gy_q) * VW'(gy_q)));
		end
		if (state_q == B_ADD) begin
			val_q  <= sqx_q + sqy_q;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= NW'(MW - 1);
		end
		// restoring square root, two radicand bits per step
		if (state_q == B_ROOT) begin
			val_q <= val_q << 2;
			cnt_q <= cnt_q - 1'b1;
			if (rem_in >= trial) begin
				rem_q  <= rem_in - trial;
				root_q <= {root_q[MW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_in;
				root_q <= {root_q[MW-2:0], 1'b0};
			end
		end
		if (load_out) begin
			out_col    <= col_q;
			out_row    <= row_q;
			grad_x     <= gx_q;
			grad_y     <= gy_q;
			magnitude  <= root_q;
			run_last   <= flags_q.run_last;
			frame_done <= flags_q.frame_done;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/sobel_gradient_magnitude_unit.sv
// Sobel 3x3 gradient and magnitude over a raster-order pixel plane. The front
// takes a pixel with a line store read, then updates its window; each result
// the pixel releases then enters the job queue from the emit state. The back
// computes one result at a time (square, add, one square root bit per cycle,
// output load), so the square root iteration sets the sustained rate; pixels
// that release no result (the first row of a plane and the first column of
// each later row) do not reach the back. Results come one row and one column
// behind their center pixel; a pixel releases up to two at a row end or in the
// last row, four at the last row's end. Line stores need no clearing after reset.
// Top level: sgm_front, sgm_fifo, sgm_back. Depends on sgm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sobel_gradient_magnitude_unit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096,
	parameter int PIXEL_BITS = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sgm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sgm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           pixel_valid,
	output logic                                pixel_ready,
	input  wire logic [PIXEL_BITS-1:0]          pixel,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [$clog2(MAX_WIDTH)-1:0]        out_col,
	output logic [$clog2(MAX_HEIGHT)-1:0]       out_row,
	output logic signed [PIXEL_BITS+2:0]        grad_x,
	output logic signed [PIXEL_BITS+2:0]        grad_y,
	output logic [PIXEL_BITS+2:0]               magnitude,
	output logic                                run_last,
	output logic                                frame_done
);
	import sgm_pkg::*;

	localparam int JOB_W = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) +
	                       2 * (PIXEL_BITS + 3) + $bits(sgm_flags_t);

	logic             push, full, pop, empty;
	logic [JOB_W-1:0] push_data, pop_data;

	sgm_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.PIXEL_BITS(PIXEL_BITS),
		.JOB_W     (JOB_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.pixel      (pixel),
		.job_push   (push),
		.job_data   (push_data),
		.job_full   (full)
	);

	sgm_fifo #(
		.DATA_W(JOB_W),
		.DEPTH (4)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	sgm_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.PIXEL_BITS(PIXEL_BITS),
		.JOB_W     (JOB_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (empty),
		.job_pop   (pop),
		.job_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_col   (out_col),
		.out_row   (out_row),
		.grad_x    (grad_x),
		.grad_y    (grad_y),
		.magnitude (magnitude),
		.run_last  (run_last),
		.frame_done(frame_done)
	);

endmodule
`default_nettype wire

// File: hw/rtl/sgm_checker.sv
// sgm_checker: port-level checks on the Sobel gradient magnitude unit.
// Bound to sobel_gradient_magnitude_unit below.
`timescale 1ns / 1ps
`default_nettype none
module sgm_checker #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096,
	parameter int PIXEL_BITS = 8
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic [$clog2(MAX_WIDTH)-1:0]    out_col,
	input wire logic [$clog2(MAX_HEIGHT)-1:0]   out_row,
	input wire logic signed [PIXEL_BITS+2:0]    grad_x,
	input wire logic signed [PIXEL_BITS+2:0]    grad_y,
	input wire logic [PIXEL_BITS+2:0]           magnitude,
	input wire logic                            run_last,
	input wire logic                            frame_done
);
	localparam int GW = PIXEL_BITS + 3;

	logic signed [GW:0] mag_s, gx_s, gy_s;
	assign mag_s = $signed({1'b0, magnitude});
	assign gx_s  = (GW + 1)'(grad_x);
	assign gy_s  = (GW + 1)'(grad_y);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(out_col))
		else $error("result dropped or changed while stalled");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> run_last)
		else $error("plane end item not last of its pixel");

	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mag_s >= gx_s && mag_s >= -gx_s && mag_s >= gy_s && mag_s >= -gy_s)
		else $error("magnitude below a gradient component");

	a_new_plane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && frame_done |=> !out_valid || out_row == '0)
		else $error("plane after frame end does not restart at row zero");

endmodule

bind sobel_gradient_magnitude_unit sgm_checker #(
	.MAX_WIDTH (MAX_WIDTH),
	.MAX_HEIGHT(MAX_HEIGHT),
	.PIXEL_BITS(PIXEL_BITS)
) u_sgm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_col   (out_col),
	.out_row   (out_row),
	.grad_x    (grad_x),
	.grad_y    (grad_y),
	.magnitude (magnitude),
	.run_last  (run_last),
	.frame_done(frame_done)
);
`default_nettype wire

// File: tb/sobel_gradient_magnitude_unit_tb.sv
// Testbench for sobel_gradient_magnitude_unit: random and directed pixel planes,
// results checked field by field against an in-bench Sobel predictor.
// Depends on sgm_pkg and the unit RTL.
`timescale 1ns / 1ps
module sobel_gradient_magnitude_unit_tb;
	import sgm_pkg::*;

	typedef struct {
		logic [10:0] col;
		logic [11:0] row;
		logic signed [10:0] gx;
		logic signed [10:0] gy;
		logic [10:0] mag;
		logic last;
		logic done;
	} sobel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic pixel_valid = 1'b0;
	logic pixel_ready;
	logic [7:0] pixel = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [10:0] out_col;
	logic [11:0] out_row;
	logic signed [10:0] grad_x, grad_y;
	logic [10:0] magnitude;
	logic run_last, frame_done;

	sobel_gradient_magnitude_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
		.pixel(pixel), .out_valid(out_valid), .out_ready(out_ready), .out_col(out_col),
		.out_row(out_row), .grad_x(grad_x), .grad_y(grad_y), .magnitude(magnitude),
		.run_last(run_last), .frame_done(frame_done)
	);

	always #5 clk = ~clk;

	// predictor state
	int unsigned width_reg = 640, height_reg = 480, border_reg = 1;
	int line_upper[2048];
	int line_middle[2048];
	int win[9];
	int col_cnt = 0, row_cnt = 0;
	sobel_result_t pending_results[$];

	int error_count = 0;
	bit stall_enable = 0;
	bit gap_enable = 0;
	bit long_hold_req = 0;
	int hold_cycles = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int int_sqrt(int v);
		int r, t, b;
		r = 0;
		for (b = 10; b >= 0; b--) begin
			t = r | (1 << b);
			if (t * t <= v) r = t;
		end
		return r;
	endfunction

	// row/column selectors: -1 marks a neighbor outside the frame
	function automatic sobel_result_t gradient_at(int rt, int rm, int rb, int cl, int cm, int cr,
			int col, int row, bit done);
		int rs[3];
		int cs[3];
		int g[3][3];
		int i, j, rr, cc, v, gx, gy;
		sobel_result_t res;
		rs[0] = rt; rs[1] = rm; rs[2] = rb;
		cs[0] = cl; cs[1] = cm; cs[2] = cr;
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				rr = rs[i] < 0 ? rs[1] : rs[i];
				cc = cs[j] < 0 ? cs[1] : cs[j];
				v = win[rr * 3 + cc];
				if ((rs[i] < 0 || cs[j] < 0) && border_reg == 0) v = 0;
				g[i][j] = v;
			end
		end
		gx = (g[0][0] + 2 * g[1][0] + g[2][0]) - (g[0][2] + 2 * g[1][2] + g[2][2]);
		gy = (g[0][0] + 2 * g[0][1] + g[0][2]) - (g[2][0] + 2 * g[2][1] + g[2][2]);
		res.col = col[10:0];
		res.row = row[11:0];
		res.gx = gx[10:0];
		res.gy = gy[10:0];
		res.mag = int_sqrt(gx * gx + gy * gy);
		res.last = 1'b0;
		res.done = done;
		return res;
	endfunction

	task automatic predict_pixel(input logic [7:0] p);
		int w, h, c, r, idx, a, b, i;
		bit row_end, last_row;
		sobel_result_t batch[$];
		w = width_reg < 3 ? 3 : (width_reg > 2048 ? 2048 : width_reg);
		h = height_reg < 3 ? 3 : (height_reg > 4096 ? 4096 : height_reg);
		c = col_cnt;
		r = row_cnt;
		idx = c < 2048 ? c : 2047;
		a = line_upper[idx];
		b = line_middle[idx];
		line_upper[idx] = b;
		line_middle[idx] = p;
		for (i = 0; i < 3; i++) begin
			win[i * 3] = win[i * 3 + 1];
			win[i * 3 + 1] = win[i * 3 + 2];
		end
		win[2] = a;
		win[5] = b;
		win[8] = p;
		row_end = c >= w - 1;
		last_row = r >= h - 1;
		if (r >= 1) begin
			if (c >= 1)
				batch.push_back(gradient_at(r == 1 ? -1 : 0, 1, 2, c == 1 ? -1 : 0, 1, 2,
					c - 1, r - 1, 0));
			if (row_end)
				batch.push_back(gradient_at(r == 1 ? -1 : 0, 1, 2, c == 0 ? -1 : 1, 2, -1,
					c, r - 1, 0));
			if (last_row) begin
				if (c >= 1)
					batch.push_back(gradient_at(1, 2, -1, c == 1 ? -1 : 0, 1, 2, c - 1, r, 0));
				if (row_end)
					batch.push_back(gradient_at(1, 2, -1, c == 0 ? -1 : 1, 2, -1, c, r, 1));
			end
		end
		if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) pending_results.push_back(batch[i]);
		if (row_end) begin
			col_cnt = 0;
			row_cnt = last_row ? 0 : ((r + 1) & 12'hFFF);
		end else begin
			col_cnt = (c + 1) & 11'h7FF;
		end
	endtask

	task automatic send_pixel(input logic [7:0] p);
		int gap;
		pixel_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (!pixel_ready);
		predict_pixel(p);
		if (gap_enable && $urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain;
		pixel_valid <= 1'b0;
		@(posedge clk);
		wait (pending_results.size() == 0);
		// a first-row pixel may still be in the front
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FRAME_WIDTH) width_reg = val & 12'hFFF;
		else if (idx == REG_FRAME_HEIGHT) height_reg = val & 13'h1FFF;
		else if (idx == REG_BORDER_MODE) border_reg = val & 1;
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h, input int unsigned bm);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_BORDER_MODE, bm);
	endtask

	function automatic int eff_pixels();
		int w, h;
		w = width_reg < 3 ? 3 : (width_reg > 2048 ? 2048 : width_reg);
		h = height_reg < 3 ? 3 : (height_reg > 4096 ? 4096 : height_reg);
		return w * h;
	endfunction

	// receiver: short and long stalls, plus forced hold-off
	always @(posedge clk) begin
		if (long_hold_req) begin
			out_ready <= 1'b0;
			hold_cycles <= 400;
			long_hold_req = 1'b0;
		end else if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (!stall_enable) begin
			out_ready <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			if ($urandom_range(0, 9) == 0) hold_cycles <= $urandom_range(20, 60);
			else hold_cycles <= $urandom_range(0, 3);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		sobel_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result col %0d row %0d", out_col, out_row));
			end else begin
				e = pending_results.pop_front();
				if (out_col !== e.col || out_row !== e.row || grad_x !== e.gx
						|| grad_y !== e.gy || magnitude !== e.mag || run_last !== e.last
						|| frame_done !== e.done)
					report_mismatch($sformatf(
						"got c%0d r%0d gx%0d gy%0d m%0d l%b d%b exp c%0d r%0d gx%0d gy%0d m%0d l%b d%b",
						out_col, out_row, grad_x, grad_y, magnitude, run_last, frame_done,
						e.col, e.row, e.gx, e.gy, e.mag, e.last, e.done));
			end
		end
	end

	// widest plane of the run first so every column used later gets written
	task automatic test_wide_plane;
		int i;
		set_frame(16, 3, 1);
		for (i = 0; i < eff_pixels(); i++)
			send_pixel((i % 7 == 0) ? 8'hFF : ((i % 11 == 0) ? 8'h00 : 8'($urandom)));
		drain();
	endtask

	task automatic test_directed_extremes;
		int i;
		// under-range sizes saturate to 3x3; zero border
		set_frame(0, 1, 0);
		for (i = 0; i < 9; i++) send_pixel(8'hFF);
		set_frame(3, 3, 1);
		for (i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'hFF : 8'h00);
		write_reg(REG_BORDER_MODE, 0);
		for (i = 0; i < 9; i++) send_pixel((i < 3) ? 8'hFF : ((i < 6) ? 8'h55 : 8'hAA));
		drain();
	endtask

	task automatic test_tall_plane;
		int i;
		set_frame(3, 12, 1);
		for (i = 0; i < eff_pixels(); i++) send_pixel(8'($urandom));
		drain();
	endtask

	// sizes changed while a plane is partly through
	task automatic test_midplane_change;
		int i;
		set_frame(6, 6, 1);
		for (i = 0; i < 14; i++) send_pixel(8'($urandom));
		write_reg(REG_FRAME_WIDTH, 4);
		for (i = 0; i < 9; i++) send_pixel(8'($urandom));
		write_reg(REG_FRAME_HEIGHT, 3);
		for (i = 0; i < 20; i++) send_pixel(8'($urandom));
		set_frame(5, 4, 1);
		while (col_cnt != 0 || row_cnt != 0) send_pixel(8'($urandom));
		drain();
	endtask

	task automatic test_random_planes;
		int sent, n, i, frame;
		sent = 0;
		frame = 0;
		stall_enable = 1;
		gap_enable = 1;
		while (sent < 210) begin
			set_frame($urandom_range(3, 12), $urandom_range(3, 8), $urandom_range(0, 1));
			n = eff_pixels();
			// occasionally break off early; next plane continues the counters
			if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
			if (frame == 1) long_hold_req = 1'b1;
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0) send_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00);
				else send_pixel(8'($urandom));
				if (frame == 2 && i == n / 2) begin
					pixel_valid <= 1'b0;
					@(posedge clk);
					wait (pending_results.size() == 0);
				end
			end
			sent += n;
			frame++;
		end
		drain();
		gap_enable = 0;
		stall_enable = 0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_wide_plane();
		test_directed_extremes();
		test_tall_plane();
		test_midplane_change();
		test_random_planes();
		drain();
		repeat (100) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
